// File: rtl/mhpq_pkg.sv
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned TOTAL_W = 9;

    localparam logic K_INSERT = 1'b0;
    localparam logic K_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_UP,
        S_DN0,
        S_DNL,
        S_DNR,
        S_PUT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                      kind;
        logic signed [DATA_W-1:0]  value;
    } t_item;

    typedef struct packed {
        logic [1:0]                status;
        logic [TOTAL_W-1:0]        entry_total;
        logic                      top_valid;
        logic signed [DATA_W-1:0]  top_value;
    } t_result;

endpackage

// File: rtl/mhpq_in_if.sv
`timescale 1ns / 1ps

interface mhpq_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [31:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink (input valid, input kind, input value, output ready);
endinterface

// File: rtl/mhpq_out_if.sv
`timescale 1ns / 1ps

interface mhpq_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [8:0]         entry_total;
    logic               top_valid;
    logic signed [31:0] top_value;

    modport source (output valid, output status, output entry_total, output top_valid,
                    output top_value, input ready);
    modport sink (input valid, input status, input entry_total, input top_valid,
                  input top_value, output ready);
endinterface

// File: rtl/mhpq_core.sv
`timescale 1ns / 1ps

module mhpq_core
    import mhpq_pkg::*;
#(
    parameter int unsigned CAPACITY = 256
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_item   i_item,
    input  logic    i_out_free,
    output logic    o_ready,
    output logic    o_done,
    output t_result o_result
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic signed [DATA_W-1:0] heap_mem [CAPACITY];

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_idx, n_idx;
    logic [AW-1:0]            r_cidx, n_cidx;
    logic                     r_pend, n_pend;
    logic [AW-1:0]            r_pos, n_pos;
    logic [AW-1:0]            r_bidx, n_bidx;
    logic signed [DATA_W-1:0] r_bval, n_bval;
    logic signed [DATA_W-1:0] r_val, n_val;
    logic signed [DATA_W-1:0] r_key, n_key;
    logic                     r_kind, n_kind;
    logic                     r_first, n_first;
    t_status                  r_status, n_status;
    logic signed [DATA_W-1:0] r_top;
    logic signed [DATA_W-1:0] r_rdata;

    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic signed [DATA_W-1:0] wr_data;

    logic                     full;
    logic [CW-1:0]            count_dec;
    logic [AW-1:0]            pos_par;
    logic [AW-1:0]            par_par;
    logic [AW-1:0]            ins_par;
    logic [CW:0]              lft;
    logic [CW:0]              rgt;
    logic                     scan_hit;
    logic                     scan_miss;
    logic [AW-1:0]            cand_idx;
    logic signed [DATA_W-1:0] cand_val;
    logic                     decide;

    assign full      = (r_count == CW'(CAPACITY));
    assign count_dec = r_count - 1'b1;
    assign pos_par   = AW'((r_pos - 1'b1) >> 1);
    assign par_par   = AW'((pos_par - 1'b1) >> 1);
    assign ins_par   = AW'((r_count - 1'b1) >> 1);
    assign lft       = (CW + 1)'({r_pos, 1'b1});
    assign rgt       = lft + 1'b1;
    assign scan_hit  = r_pend && (r_rdata == r_key);
    assign scan_miss = !scan_hit && (r_idx >= r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_cidx   <= n_cidx;
        r_pos    <= n_pos;
        r_bidx   <= n_bidx;
        r_bval   <= n_bval;
        r_val    <= n_val;
        r_key    <= n_key;
        r_kind   <= n_kind;
        r_first  <= n_first;
        r_status <= n_status;
        if (wr_en && (wr_addr == '0)) begin
            r_top <= wr_data;
        end
    end

    // Simple dual-port style storage: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            heap_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= heap_mem[rd_addr];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_cidx   = r_cidx;
        n_pend   = r_pend;
        n_pos    = r_pos;
        n_bidx   = r_bidx;
        n_bval   = r_bval;
        n_val    = r_val;
        n_key    = r_key;
        n_kind   = r_kind;
        n_first  = r_first;
        n_status = r_status;
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = r_pos;
        wr_data  = r_val;
        cand_idx = r_bidx;
        cand_val = r_bval;
        decide   = 1'b0;
        o_ready  = 1'b0;
        o_done   = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_start) begin
                    n_kind   = i_item.kind;
                    n_val    = i_item.value;
                    n_key    = i_item.value;
                    n_first  = 1'b1;
                    n_status = ST_DONE;
                    if (i_item.kind == K_DELETE) begin
                        n_idx   = '0;
                        n_pend  = 1'b0;
                        n_state = S_SCAN;
                    end else if (full) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_pos   = AW'(r_count);
                        n_count = r_count + 1'b1;
                        if (r_count == '0) begin
                            n_state = S_PUT;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = ins_par;
                            n_state = S_UP;
                        end
                    end
                end
            end
            S_SCAN: begin
                // Reads are issued one slot ahead of the compare.
                if (scan_hit) begin
                    n_count = count_dec;
                    n_pos   = r_cidx;
                    if (CW'(r_cidx) == count_dec) begin
                        n_state = S_DONE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(count_dec);
                        n_state = S_LAST;
                    end
                end else if (scan_miss) begin
                    n_status = ST_MISS;
                    n_state  = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_idx);
                    n_cidx  = AW'(r_idx);
                    n_idx   = r_idx + 1'b1;
                    n_pend  = 1'b1;
                end
            end
            S_LAST: begin
                n_val = r_rdata;
                if (r_pos != '0) begin
                    rd_en   = 1'b1;
                    rd_addr = pos_par;
                    n_first = 1'b1;
                    n_state = S_UP;
                end else begin
                    n_state = S_DN0;
                end
            end
            S_UP: begin
                // The moving value is held aside; parents shift down into the hole.
                if (r_rdata < r_val) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pos;
                    wr_data = r_rdata;
                    n_pos   = pos_par;
                    n_first = 1'b0;
                    if (pos_par == '0) begin
                        n_state = S_PUT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = par_par;
                    end
                end else if (r_first && (r_kind == K_DELETE)) begin
                    n_state = S_DN0;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_DN0: begin
                if (lft < (CW + 1)'(r_count)) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(lft);
                    n_state = S_DNL;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_DNL: begin
                if (r_val < r_rdata) begin
                    cand_idx = AW'(lft);
                    cand_val = r_rdata;
                end else begin
                    cand_idx = r_pos;
                    cand_val = r_val;
                end
                n_bidx = cand_idx;
                n_bval = cand_val;
                if (rgt < (CW + 1)'(r_count)) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(rgt);
                    n_state = S_DNR;
                end else begin
                    decide = 1'b1;
                end
            end
            S_DNR: begin
                if (r_bval < r_rdata) begin
                    cand_idx = AW'(rgt);
                    cand_val = r_rdata;
                end
                decide = 1'b1;
            end
            S_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_pos;
                wr_data = r_val;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Sift-down step: the larger child moves up into the hole.
        if (decide) begin
            if (cand_idx == r_pos) begin
                n_state = S_PUT;
            end else begin
                wr_en   = 1'b1;
                wr_addr = r_pos;
                wr_data = cand_val;
                n_pos   = cand_idx;
                n_state = S_DN0;
            end
        end
    end

    always_comb begin
        o_result.status      = r_status;
        o_result.entry_total = TOTAL_W'(r_count);
        o_result.top_valid   = (r_count != '0);
        o_result.top_value   = (r_count != '0) ? r_top : '0;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("heap entry count exceeds capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start && i_item.kind == K_INSERT && !full)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted insert did not grow the heap");

    a_miss_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && scan_miss) |=> (r_count == $past(r_count)))
        else $error("delete miss changed the entry count");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write hit the same slot in one cycle");
`endif

endmodule

// File: rtl/max_heap_priority_queue.sv
`timescale 1ns / 1ps
// Insert: a full heap answers with status FULL; else a sift-up with one storage read per level.
// Delete: linear scan at one read per cycle, MISS if absent; then one read of the last entry,
// which moves into the freed slot and sifts up (one read per level) or down (one read per child).
// One transaction is in work at a time; the next is taken while a result waits.
// Reset empties the heap at once; the storage is not cleared and needs no pass.

module max_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int unsigned CAPACITY = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mhpq_in_if.sink    i_req,
    mhpq_out_if.source o_rsp
);

    logic    core_ready;
    logic    core_done;
    logic    out_free;
    t_item   item;
    t_result result;

    logic    r_out_valid;
    t_result r_out;

    assign item.kind   = i_req.kind;
    assign item.value  = i_req.value;
    assign i_req.ready = core_ready;
    assign out_free    = !r_out_valid || o_rsp.ready;

    mhpq_core #(
        .CAPACITY (CAPACITY)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_req.valid),
        .i_item     (item),
        .i_out_free (out_free),
        .o_ready    (core_ready),
        .o_done     (core_done),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_done) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_done) begin
            r_out <= result;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.entry_total = r_out.entry_total;
    assign o_rsp.top_valid   = r_out.top_valid;
    assign o_rsp.top_value   = r_out.top_value;

endmodule
